// ===== rtl/gdd_pkg.sv =====
package gdd_pkg;

    localparam int MAX_YEAR_DEF = 4095;
    localparam int BASE_YEAR    = 1900;
    localparam int MONTHS       = 12;
    localparam int MONTH_FEB    = 2;
    localparam int DAYS_YEAR    = 365;
    localparam int COUNT_W      = 20;
    localparam int DN_W         = 21;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // floor(q / 25) == (q * RECIP_25) >> RECIP_SH for every 10-bit q.
    localparam int RECIP_25 = 1311;
    localparam int RECIP_SH = 15;

    typedef struct packed {
        logic [11:0] first_year;
        logic [3:0]  first_month;
        logic [4:0]  first_day;
        logic [11:0] second_year;
        logic [3:0]  second_month;
        logic [4:0]  second_day;
    } gdd_req_t;

    typedef struct packed {
        logic               first_valid;
        logic               second_valid;
        logic               first_later;
        logic [COUNT_W-1:0] day_count;
    } gdd_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic quot;
        logic sum;
        logic days;
        logic sel;
        logic cmp;
    } gdd_cmd_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd1:    n = 5'd31;
            4'd2:    n = 5'd28;
            4'd3:    n = 5'd31;
            4'd4:    n = 5'd30;
            4'd5:    n = 5'd31;
            4'd6:    n = 5'd30;
            4'd7:    n = 5'd31;
            4'd8:    n = 5'd31;
            4'd9:    n = 5'd30;
            4'd10:   n = 5'd31;
            4'd11:   n = 5'd30;
            4'd12:   n = 5'd31;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/gdd_ctrl.sv =====
module gdd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output gdd_pkg::gdd_cmd_t cmd
);
    import gdd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_QUOT = 6'b000010,
        S_SUM  = 6'b000100,
        S_DAYS = 6'b001000,
        S_CMP  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                sel_next = 1'b0;
                if (start)
                begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT: state_next = S_SUM;
            S_SUM:  state_next = S_DAYS;
            S_DAYS:
            begin
                // The day-number unit serves the first date, then the second.
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = S_QUOT;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_OUT);
    assign cmd.load = start && (state_reg == S_IDLE);
    assign cmd.quot = (state_reg == S_QUOT);
    assign cmd.sum  = (state_reg == S_SUM);
    assign cmd.days = (state_reg == S_DAYS);
    assign cmd.cmp  = (state_reg == S_CMP);
    assign cmd.sel  = sel_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    a_both_dates: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp |-> sel_reg && $past(cmd.days))
        else $error("compare reached before both dates were converted");

endmodule

// ===== rtl/gdd_dpath.sv =====
module gdd_dpath #(
    parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gdd_pkg::gdd_cmd_t cmd,
    input  logic              done,
    input  gdd_pkg::gdd_req_t request,
    output gdd_pkg::gdd_res_t result
);
    import gdd_pkg::*;

    gdd_req_t        req_reg;
    logic [5:0]      cp_reg;
    logic [5:0]      cy_reg;
    logic            leap_reg;
    logic [DN_W-1:0] acc_reg;
    logic [DN_W-1:0] dn_a_reg, dn_b_reg;
    logic            v1_reg, v2_reg;
    gdd_res_t        res_reg, res_next;

    logic [11:0]     y, p;
    logic [3:0]      m;
    logic [4:0]      d;
    logic [20:0]     pm, ym;
    logic [9:0]      c25;
    logic            leap_next;
    logic [DN_W-1:0] acc_next;
    logic [4:0]      mlen;
    logic            feb_extra, late_extra;
    logic            year_ok, valid_next;
    logic [DN_W-1:0] dn_next;
    logic [DN_W-1:0] diff;

    always_comb
    begin
        y = cmd.sel ? req_reg.second_year  : req_reg.first_year;
        m = cmd.sel ? req_reg.second_month : req_reg.first_month;
        d = cmd.sel ? req_reg.second_day   : req_reg.first_day;
        p = y - 12'd1;

        // Quotients by 100 through a reciprocal of 25 applied to the value over 4.
        pm = 21'(p[11:2]) * 21'(RECIP_25);
        ym = 21'(y[11:2]) * 21'(RECIP_25);

        // A year divisible by 4 is a century year when its quarter is a multiple of 25.
        c25       = 10'(cy_reg) * 10'd25;
        leap_next = (y[1:0] == 2'd0) && ((c25 != y[11:2]) || (cy_reg[1:0] == 2'd0));
        acc_next  = 21'(p) * 21'(DAYS_YEAR) + 21'(p[11:2]) - 21'(cp_reg)
                    + 21'(cp_reg[5:2]);

        feb_extra  = leap_reg && (m == 4'(MONTH_FEB));
        late_extra = leap_reg && (m > 4'(MONTH_FEB));
        mlen       = month_len(m) + 5'(feb_extra);
        year_ok    = (y >= 12'(BASE_YEAR)) && (32'(y) <= 32'(MAX_YEAR));
        valid_next = year_ok && (m >= 4'd1) && (m <= 4'(MONTHS))
                     && (d != 5'd0) && (d <= mlen);
        dn_next    = acc_reg + 21'(month_start(m)) + 21'(d) + 21'(late_extra);

        diff = (dn_a_reg > dn_b_reg) ? (dn_a_reg - dn_b_reg) : (dn_b_reg - dn_a_reg);
        res_next.first_valid  = v1_reg;
        res_next.second_valid = v2_reg;
        res_next.first_later  =
            {req_reg.first_year, req_reg.first_month, req_reg.first_day} >
            {req_reg.second_year, req_reg.second_month, req_reg.second_day};
        if (!(v1_reg && v2_reg))
        begin
            res_next.day_count = '0;
        end
        else if (diff > DN_W'(COUNT_MAX))
        begin
            res_next.day_count = COUNT_MAX;
        end
        else
        begin
            res_next.day_count = diff[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.quot)
        begin
            cp_reg <= pm[RECIP_SH +: 6];
            cy_reg <= ym[RECIP_SH +: 6];
        end
        if (cmd.sum)
        begin
            leap_reg <= leap_next;
            acc_reg  <= acc_next;
        end
        if (cmd.days)
        begin
            if (cmd.sel)
            begin
                dn_b_reg <= dn_next;
                v2_reg   <= valid_next;
            end
            else
            begin
                dn_a_reg <= dn_next;
                v1_reg   <= valid_next;
            end
        end
        if (cmd.cmp)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

    a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.day_count != '0) |-> result.first_valid && result.second_valid)
        else $error("non-zero day count reported for an invalid date");

    a_equal_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.first_valid && result.second_valid && (result.day_count == '0)
        |-> !result.first_later)
        else $error("equal valid dates reported as ordered");

endmodule

// ===== rtl/gregorian_date_difference.sv =====
// The result strobe done rises in S_OUT, after the controller has run S_QUOT, S_SUM and
// S_DAYS for each date and then S_CMP; the result is taken while done is high.
// A new item is accepted only once the block is idle again; busy falls the cycle after done.
// The shared day-number unit takes three steps per date and serves both dates in turn.
// The result is shown for a single cycle on done; the receiver cannot stall it.
// Reset (rst_n low, asynchronous) returns the controller to idle; an item in flight is dropped.
module gregorian_date_difference #(
    parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gdd_pkg::gdd_req_t request,
    output logic              done,
    output gdd_pkg::gdd_res_t result
);
    import gdd_pkg::*;

    gdd_cmd_t cmd;

    gdd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    gdd_dpath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .done    (done),
        .request (request),
        .result  (result)
    );

endmodule
